// ===== rtl/bam_pkg.sv =====
// Shared types, constants and the level quantizer of the battery average monitor.
package bam_pkg;

  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned VOLT_W    = 7;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned REPORT_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Reciprocal widths for exact division of a sequence number or a burst sum by a constant.
  localparam int unsigned SEQ_RECIP_W = 18;
  localparam int unsigned SUM_RECIP_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT    = 3'd0,
    CFG_LEVEL_ONE    = 3'd1,
    CFG_LEVEL_TWO    = 3'd2,
    CFG_LEVEL_THREE  = 3'd3,
    CFG_LEVEL_FOUR   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [VOLT_W-1:0] low_limit;
    logic [VOLT_W-1:0] level_one;
    logic [VOLT_W-1:0] level_two;
    logic [VOLT_W-1:0] level_three;
    logic [VOLT_W-1:0] level_four;
  } cfg_regs_t;

  localparam logic [VOLT_W-1:0] LOW_LIMIT_RST   = 7'd50;
  localparam logic [VOLT_W-1:0] LEVEL_ONE_RST   = 7'd52;
  localparam logic [VOLT_W-1:0] LEVEL_TWO_RST   = 7'd55;
  localparam logic [VOLT_W-1:0] LEVEL_THREE_RST = 7'd58;
  localparam logic [VOLT_W-1:0] LEVEL_FOUR_RST  = 7'd61;

  // Bounds are tested in order; they need not be ascending.
  function automatic logic [LEVEL_W-1:0] quantize(input logic [VOLT_W-1:0] v,
                                                  input cfg_regs_t cfg);
    logic [LEVEL_W-1:0] lvl;
    if (v < cfg.level_one) begin
      lvl = 3'd0;
    end else if (v < cfg.level_two) begin
      lvl = 3'd1;
    end else if (v < cfg.level_three) begin
      lvl = 3'd2;
    end else if (v <= cfg.level_four) begin
      lvl = 3'd3;
    end else begin
      lvl = 3'd4;
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/battery_average_monitor.sv =====
// Battery average monitor: burst sampling, averaging, low flag and level quantization.
// A request accepted passes through the input register and then the result register
// before its result is on the outputs.
// Throughput: one request per cycle while out_stall is low; the period test and the average
// each use one constant-reciprocal multiply, and a stalled result holds the input register.
// Reset clears the burst state, the flags and the valid bits and loads default limits.
module battery_average_monitor #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 5,
  parameter int unsigned SAMPLE_PERIOD       = 600
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bam_pkg::VOLT_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [bam_pkg::SEQ_W-1:0]        seq_number,
  input  logic [bam_pkg::VOLT_W-1:0]       supply_sample,
  input  logic                             charging,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             sample_taken,
  output logic                             average_done,
  output logic                             low_battery,
  output logic [bam_pkg::LEVEL_W-1:0]      charge_level,
  output logic [bam_pkg::REPORT_W-1:0]     battery_report
);

  localparam int unsigned SEQ_W    = bam_pkg::SEQ_W;
  localparam int unsigned VOLT_W   = bam_pkg::VOLT_W;
  localparam int unsigned SUM_W    = bam_pkg::SUM_W;
  localparam int unsigned COUNT_W  = bam_pkg::COUNT_W;
  localparam int unsigned LEVEL_W  = bam_pkg::LEVEL_W;
  localparam int unsigned SRW      = bam_pkg::SEQ_RECIP_W;
  localparam int unsigned ARW      = bam_pkg::SUM_RECIP_W;

  // q = (n * M) >> S with M = floor(2^S / d) + 1 and S = width(n) + clog2(d) is exact.
  localparam int unsigned SEQ_SHIFT = SEQ_W + $clog2(SAMPLE_PERIOD);
  localparam logic [47:0] SEQ_RECIP_FULL =
      (48'd1 << SEQ_SHIFT) / 48'(SAMPLE_PERIOD) + 48'd1;
  localparam logic [SRW-1:0] SEQ_RECIP = SEQ_RECIP_FULL[SRW-1:0];
  localparam logic [SEQ_W-1:0] PERIOD = SEQ_W'(SAMPLE_PERIOD);

  localparam int unsigned AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [31:0] AVG_RECIP_FULL =
      (32'd1 << AVG_SHIFT) / 32'(SAMPLES_PER_AVERAGE) + 32'd1;
  localparam logic [ARW-1:0] AVG_RECIP = AVG_RECIP_FULL[ARW-1:0];
  localparam logic [COUNT_W-1:0] BURST_LEN = COUNT_W'(SAMPLES_PER_AVERAGE);

  bam_pkg::cfg_regs_t cfg;

  // Input register
  logic                  s1_valid;
  logic                  s1_op;
  logic [SEQ_W-1:0]      s1_seq;
  logic [VOLT_W-1:0]     s1_sample;
  logic                  s1_charging;
  logic [SEQ_W-1:0]      s1_quot;

  // Burst and report state
  logic [SUM_W-1:0]      sample_sum;
  logic [COUNT_W-1:0]    sample_count;
  logic [VOLT_W-1:0]     reported_voltage;
  logic                  low_flag;
  logic [LEVEL_W-1:0]    level_store;

  logic [SUM_W-1:0]      sample_sum_next;
  logic [COUNT_W-1:0]    sample_count_next;
  logic [VOLT_W-1:0]     reported_voltage_next;
  logic                  low_flag_next;
  logic [LEVEL_W-1:0]    level_store_next;
  logic                  taken_next;
  logic                  done_next;

  logic [SEQ_W+SRW-1:0]  seq_prod;
  logic [2*SEQ_W-1:0]    period_back;
  logic                  on_period;
  logic [SUM_W-1:0]      sum_acc;
  logic [COUNT_W-1:0]    count_inc;
  logic [SUM_W+ARW-1:0]  avg_prod;
  logic [VOLT_W-1:0]     avg;
  logic                  s1_fire;
  logic                  in_fire;

  // The quotient for the period test is formed before the input register.
  assign seq_prod = (SEQ_W+SRW)'(seq_number) * (SEQ_W+SRW)'(SEQ_RECIP);

  assign s1_fire  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  assign period_back = (2*SEQ_W)'(s1_quot) * (2*SEQ_W)'(PERIOD);
  assign on_period   = (period_back == (2*SEQ_W)'(s1_seq));
  assign sum_acc     = sample_sum + SUM_W'(s1_sample);
  assign count_inc   = sample_count + COUNT_W'(1);
  assign avg_prod    = (SUM_W+ARW)'(sum_acc) * (SUM_W+ARW)'(AVG_RECIP);
  // The average of samples of at most seven bits never exceeds seven bits.
  assign avg         = VOLT_W'(avg_prod >> AVG_SHIFT);

  always_comb begin
    sample_sum_next       = sample_sum;
    sample_count_next     = sample_count;
    reported_voltage_next = reported_voltage;
    low_flag_next         = low_flag;
    level_store_next      = level_store;
    taken_next            = 1'b0;
    done_next             = 1'b0;
    if (s1_op) begin
      reported_voltage_next = s1_sample;
      level_store_next      = bam_pkg::quantize(s1_sample, cfg);
    end else if (on_period || (sample_count != '0)) begin
      taken_next        = 1'b1;
      sample_sum_next   = sum_acc;
      sample_count_next = count_inc;
      if (count_inc >= BURST_LEN) begin
        done_next         = 1'b1;
        sample_count_next = '0;
        sample_sum_next   = '0;
        low_flag_next     = (avg < cfg.low_limit);
        if ((!s1_charging && (reported_voltage >= avg)) ||
            (s1_charging && (reported_voltage <= avg))) begin
          reported_voltage_next = avg;
          level_store_next      = bam_pkg::quantize(avg, cfg);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit   <= bam_pkg::LOW_LIMIT_RST;
      cfg.level_one   <= bam_pkg::LEVEL_ONE_RST;
      cfg.level_two   <= bam_pkg::LEVEL_TWO_RST;
      cfg.level_three <= bam_pkg::LEVEL_THREE_RST;
      cfg.level_four  <= bam_pkg::LEVEL_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bam_pkg::CFG_LOW_LIMIT:   cfg.low_limit   <= cfg_data;
        bam_pkg::CFG_LEVEL_ONE:   cfg.level_one   <= cfg_data;
        bam_pkg::CFG_LEVEL_TWO:   cfg.level_two   <= cfg_data;
        bam_pkg::CFG_LEVEL_THREE: cfg.level_three <= cfg_data;
        bam_pkg::CFG_LEVEL_FOUR:  cfg.level_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op       <= op;
      s1_seq      <= seq_number;
      s1_sample   <= supply_sample;
      s1_charging <= charging;
      s1_quot     <= SEQ_W'(seq_prod >> SEQ_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum       <= '0;
      sample_count     <= '0;
      reported_voltage <= '0;
      low_flag         <= 1'b0;
      level_store      <= '0;
    end else if (s1_fire) begin
      sample_sum       <= sample_sum_next;
      sample_count     <= sample_count_next;
      reported_voltage <= reported_voltage_next;
      low_flag         <= low_flag_next;
      level_store      <= level_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      sample_taken   <= taken_next;
      average_done   <= done_next;
      low_battery    <= low_flag_next;
      charge_level   <= level_store_next;
      battery_report <= {reported_voltage_next, 1'b0};
    end
  end

endmodule
